FILE: hdl/path_corridor_merge_defines.svh
// Assertion macros for the path corridor merge block.
// Standalone header; included by the top level only.
`ifndef PATH_CORRIDOR_MERGE_DEFINES_SVH
`define PATH_CORRIDOR_MERGE_DEFINES_SVH

`ifndef SYNTH

// Same-cycle implication, sampled on clk, quiet during reset.
`define PCM_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, sampled on clk, quiet during reset.
`define PCM_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`else

`define PCM_ASSERT_NOW(label, ante, cons, msg)
`define PCM_ASSERT_NEXT(label, ante, cons, msg)

`endif

`endif

FILE: hdl/pcm_pkg.sv
// Shared types and constants for the path corridor merge block.
// No dependencies; imported by every module of the block.
`timescale 1ns / 1ps
`default_nettype none

package pcm_pkg;

  localparam int PATH_DEPTH_DEF    = 256;
  localparam int VISITED_DEPTH_DEF = 16;

  localparam int OP_W   = 2;
  localparam int SLOT_W = 8;
  localparam int ID_W   = 32;
  localparam int PLEN_W = 9;
  localparam int VLEN_W = 5;

  localparam logic [PLEN_W-1:0] OUT_LEN_MAX = 9'd511;

  typedef enum logic [OP_W-1:0] {
    OP_WR_PATH = 2'd0,
    OP_WR_VIS  = 2'd1,
    OP_MERGE   = 2'd2,
    OP_RD_PATH = 2'd3
  } op_t;

  typedef enum logic [3:0] {
    S_IDLE,
    S_WR,
    S_RD,
    S_MSTART,
    S_P_RD,
    S_V_RD,
    S_V_CMP,
    S_PLAN,
    S_CLIP,
    S_SETUP,
    S_M_RD,
    S_M_WR,
    S_F_RD,
    S_F_WR,
    S_DONE
  } state_t;

  // Path store write source.
  typedef enum logic [1:0] {
    PW_INPUT,
    PW_MOVE,
    PW_FILL
  } pw_src_t;

  // Path store read address source.
  typedef enum logic [1:0] {
    PR_SLOT,
    PR_SCAN,
    PR_MOVE
  } pr_sel_t;

  typedef struct packed {
    logic    accept;
    logic    path_wr;
    pw_src_t pw_src;
    logic    path_rd;
    pr_sel_t pr_sel;
    logic    vis_wr;
    logic    vis_rd;
    logic    next_v;
    logic    next_p;
    logic    hit;
    logic    plan;
    logic    clip;
    logic    move_init;
    logic    move_step;
    logic    fill_init;
    logic    fill_step;
    logic    out_load;
  } cmd_t;

  typedef struct packed {
    op_t  op;
    logic eq;
    logic j_last;
    logic i_zero;
    logic n_zero;
    logic nv_zero;
    logic skip_move;
    logic cnt_last;
  } sts_t;

endpackage

`default_nettype wire

FILE: hdl/path_corridor_merge.sv
// Top level of the path corridor merge block: sequencer plus datapath.
// Depends on pcm_pkg, pcm_ctrl, pcm_dp and path_corridor_merge_defines.svh.
//
//   channel | ports                                         | direction
//   --------+-----------------------------------------------+----------
//   in      | in_valid in_stall in_op in_slot in_poly_id    | to block
//           | in_path_len in_visited_len                    |
//   out     | out_valid out_stall out_new_path_len          | from block
//           | out_read_id out_merged                        |
//
// Merge: the scan reads path entries from the end back and compares each with
// the visited entries in turn (a visited read, then a compare); on a hit the
// tail is moved and the reversed prefix filled, each entry read then written;
// with no common id it ends after the scan, with an empty length before it.
// Reset: rst_n is synchronous, active low, and clears the sequencer and
// out_valid; store contents are undefined until written.
// Stalls: one transaction in flight; in_stall is high from acceptance until
// its result sits in the output register, which holds under out_stall while
// the next input transaction may already be taken.
`timescale 1ns / 1ps
`default_nettype none
`include "path_corridor_merge_defines.svh"

module path_corridor_merge
  import pcm_pkg::*;
#(
  parameter int PATH_DEPTH    = PATH_DEPTH_DEF,
  parameter int VISITED_DEPTH = VISITED_DEPTH_DEF
) (
  input  wire logic              clk,
  input  wire logic              rst_n,
  // input channel
  input  wire logic              in_valid,
  output logic                   in_stall,
  input  wire logic [OP_W-1:0]   in_op,
  input  wire logic [SLOT_W-1:0] in_slot,
  input  wire logic [ID_W-1:0]   in_poly_id,
  input  wire logic [PLEN_W-1:0] in_path_len,
  input  wire logic [VLEN_W-1:0] in_visited_len,
  // result channel
  output logic                   out_valid,
  input  wire logic              out_stall,
  output logic [PLEN_W-1:0]      out_new_path_len,
  output logic [ID_W-1:0]        out_read_id,
  output logic                   out_merged
);

  cmd_t cmd;
  sts_t sts;

  // Sequencer: steps write, read and merge transactions, one at a time.
  pcm_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_op     (in_op),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .sts       (sts),
    .cmd       (cmd)
  );

  // Datapath: stores, scan from the path end back, tail move, reversed fill.
  pcm_dp #(
    .PATH_DEPTH    (PATH_DEPTH),
    .VISITED_DEPTH (VISITED_DEPTH)
  ) u_dp (
    .clk              (clk),
    .in_op            (in_op),
    .in_slot          (in_slot),
    .in_poly_id       (in_poly_id),
    .in_path_len      (in_path_len),
    .in_visited_len   (in_visited_len),
    .cmd              (cmd),
    .sts              (sts),
    .out_new_path_len (out_new_path_len),
    .out_read_id      (out_read_id),
    .out_merged       (out_merged)
  );

  // One transaction at a time: hold off input right after acceptance.
  `PCM_ASSERT_NEXT(a_one_in_flight, in_valid && !in_stall, in_stall, "accepted while busy")

  // Never overwrite a result that is still waiting.
  `PCM_ASSERT_NOW(a_no_overwrite, cmd.out_load, !out_valid || !out_stall, "result overwritten")

  // A merge hit always leaves at least the matched entry in the path.
  `PCM_ASSERT_NOW(a_hit_len, out_valid && out_merged, out_new_path_len != '0, "hit with empty path")

  // Read data only ever comes back on a plain read result.
  `PCM_ASSERT_NOW(a_read_only, out_valid && out_read_id != '0,
                  out_new_path_len == '0 && !out_merged, "read data on merge result")

endmodule

`default_nettype wire

FILE: hdl/pcm_ctrl.sv
// Sequencer for the path corridor merge block.
// Depends on pcm_pkg; drives the datapath through cmd_t, watches sts_t.
`timescale 1ns / 1ps
`default_nettype none

module pcm_ctrl
  import pcm_pkg::*;
(
  input  wire logic            clk,
  input  wire logic            rst_n,
  input  wire logic            in_valid,
  input  wire logic [OP_W-1:0] in_op,
  output logic                 in_stall,
  output logic                 out_valid,
  input  wire logic            out_stall,
  input  wire sts_t            sts,
  output cmd_t                 cmd
);

  state_t state_r, state_nxt;
  logic   out_valid_r, out_valid_nxt;
  logic   out_free;
  op_t    in_op_e;

  assign in_op_e   = op_t'(in_op);
  assign out_free  = !out_valid_r || !out_stall;
  assign in_stall  = (state_r != S_IDLE);
  assign out_valid = out_valid_r;

  // Next state.
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          case (in_op_e)
            OP_WR_PATH, OP_WR_VIS: state_nxt = S_WR;
            OP_MERGE:              state_nxt = S_MSTART;
            OP_RD_PATH:            state_nxt = S_RD;
            default:               state_nxt = S_IDLE;
          endcase
        end
      end
      S_WR:     state_nxt = S_DONE;
      S_RD:     state_nxt = S_DONE;
      S_MSTART: state_nxt = (sts.n_zero || sts.nv_zero) ? S_DONE : S_P_RD;
      S_P_RD:   state_nxt = S_V_RD;
      S_V_RD:   state_nxt = S_V_CMP;
      S_V_CMP: begin
        if (sts.eq) begin
          state_nxt = S_PLAN;
        end else if (!sts.j_last) begin
          state_nxt = S_V_RD;
        end else if (!sts.i_zero) begin
          state_nxt = S_P_RD;
        end else begin
          state_nxt = S_DONE;
        end
      end
      S_PLAN:   state_nxt = S_CLIP;
      S_CLIP:   state_nxt = S_SETUP;
      S_SETUP:  state_nxt = sts.skip_move ? S_F_RD : S_M_RD;
      S_M_RD:   state_nxt = S_M_WR;
      S_M_WR:   state_nxt = sts.cnt_last ? S_F_RD : S_M_RD;
      S_F_RD:   state_nxt = S_F_WR;
      S_F_WR:   state_nxt = sts.cnt_last ? S_DONE : S_F_RD;
      S_DONE:   state_nxt = out_free ? S_IDLE : S_DONE;
      default:  state_nxt = S_IDLE;
    endcase
  end

  // Commands.
  always_comb begin
    cmd        = '0;
    cmd.pw_src = PW_INPUT;
    cmd.pr_sel = PR_SLOT;
    case (state_r)
      S_IDLE: cmd.accept = in_valid;
      S_WR: begin
        cmd.path_wr = (sts.op == OP_WR_PATH);
        cmd.vis_wr  = (sts.op == OP_WR_VIS);
      end
      S_RD: begin
        cmd.path_rd = 1'b1;
        cmd.pr_sel  = PR_SLOT;
      end
      S_P_RD: begin
        cmd.path_rd = 1'b1;
        cmd.pr_sel  = PR_SCAN;
      end
      S_V_RD: cmd.vis_rd = 1'b1;
      S_V_CMP: begin
        if (sts.eq) begin
          cmd.hit = 1'b1;
        end else if (!sts.j_last) begin
          cmd.next_v = 1'b1;
        end else if (!sts.i_zero) begin
          cmd.next_p = 1'b1;
        end
      end
      S_PLAN: cmd.plan = 1'b1;
      S_CLIP: cmd.clip = 1'b1;
      S_SETUP: begin
        cmd.fill_init = sts.skip_move;
        cmd.move_init = !sts.skip_move;
      end
      S_M_RD: begin
        cmd.path_rd = 1'b1;
        cmd.pr_sel  = PR_MOVE;
      end
      S_M_WR: begin
        cmd.path_wr   = 1'b1;
        cmd.pw_src    = PW_MOVE;
        cmd.move_step = !sts.cnt_last;
        cmd.fill_init = sts.cnt_last;
      end
      S_F_RD: cmd.vis_rd = 1'b1;
      S_F_WR: begin
        cmd.path_wr   = 1'b1;
        cmd.pw_src    = PW_FILL;
        cmd.fill_step = 1'b1;
      end
      S_DONE: cmd.out_load = out_free;
      default: cmd.accept = 1'b0;
    endcase
  end

  // Result valid: set on load, drop once taken.
  always_comb begin
    out_valid_nxt = out_valid_r;
    if (cmd.out_load) begin
      out_valid_nxt = 1'b1;
    end else if (!out_stall) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

endmodule

`default_nettype wire

FILE: hdl/pcm_dp.sv
// Datapath for the path corridor merge block: both stores, scan indexes,
// move and fill counters, result registers. Depends on pcm_pkg.
`timescale 1ns / 1ps
`default_nettype none

module pcm_dp
  import pcm_pkg::*;
#(
  parameter int PATH_DEPTH    = PATH_DEPTH_DEF,
  parameter int VISITED_DEPTH = VISITED_DEPTH_DEF
) (
  input  wire logic              clk,
  input  wire logic [OP_W-1:0]   in_op,
  input  wire logic [SLOT_W-1:0] in_slot,
  input  wire logic [ID_W-1:0]   in_poly_id,
  input  wire logic [PLEN_W-1:0] in_path_len,
  input  wire logic [VLEN_W-1:0] in_visited_len,
  input  wire cmd_t              cmd,
  output sts_t                   sts,
  output logic [PLEN_W-1:0]      out_new_path_len,
  output logic [ID_W-1:0]        out_read_id,
  output logic                   out_merged
);

  localparam int PAW = $clog2(PATH_DEPTH);
  localparam int PLW = $clog2(PATH_DEPTH + 1);
  localparam int VAW = $clog2(VISITED_DEPTH);
  localparam int VLW = $clog2(VISITED_DEPTH + 1);
  localparam int CW  = ((PLW > VLW) ? PLW : VLW) + 1;

  logic [ID_W-1:0] path_mem [PATH_DEPTH];
  logic [ID_W-1:0] vis_mem  [VISITED_DEPTH];

  op_t             op_r;
  logic [SLOT_W-1:0] slot_r;
  logic [ID_W-1:0] id_r;
  logic [PLW-1:0]  n_r;
  logic [VLW-1:0]  nv_r;
  logic [PAW-1:0]  i_r;
  logic [VAW-1:0]  j_r;
  logic [PAW-1:0]  pos_r;
  logic [VAW-1:0]  vpos_r;
  logic [PLW-1:0]  req_r;
  logic [PLW-1:0]  size_r;
  logic [PLW-1:0]  pos1_r;
  logic [PLW-1:0]  len_r;
  logic            up_r;
  logic            found_r;
  logic [PAW-1:0]  src_r;
  logic [PAW-1:0]  dst_r;
  logic [PLW-1:0]  cnt_r;
  logic [ID_W-1:0] prd_r;
  logic [ID_W-1:0] vrd_r;
  logic [PLEN_W-1:0] out_len_r;
  logic [ID_W-1:0] out_id_r;
  logic            out_mrg_r;

  logic [PLW-1:0]  n_sat;
  logic [VLW-1:0]  nv_sat;
  logic            path_slot_ok;
  logic            vis_slot_ok;
  logic [CW-1:0]   req_raw, pos1_c, req_c, size_c, sum_c;
  logic            pw_en;
  logic [PAW-1:0]  pw_addr, pr_addr;
  logic [ID_W-1:0] pw_data;

  // Saturate lengths to the store depths.
  assign n_sat  = (32'(in_path_len) > 32'(PATH_DEPTH)) ? PLW'(PATH_DEPTH) : PLW'(in_path_len);
  assign nv_sat = (32'(in_visited_len) > 32'(VISITED_DEPTH)) ?
                  VLW'(VISITED_DEPTH) : VLW'(in_visited_len);

  assign path_slot_ok = 32'(slot_r) < 32'(PATH_DEPTH);
  assign vis_slot_ok  = 32'(slot_r) < 32'(VISITED_DEPTH);

  // Plan step: prefix length, clamped, and raw tail size.
  always_comb begin
    req_raw = CW'(nv_r) - CW'(vpos_r);
    pos1_c  = CW'(pos_r) + CW'(1);
    if (req_raw >= CW'(PATH_DEPTH)) begin
      req_c  = CW'(PATH_DEPTH);
      size_c = '0;
    end else begin
      req_c  = req_raw;
      size_c = CW'(n_r) - pos1_c;
    end
  end

  assign sum_c = CW'(req_r) + CW'(size_r);

  // Path store port selection.
  always_comb begin
    pw_addr = dst_r;
    pw_data = prd_r;
    pw_en   = cmd.path_wr;
    case (cmd.pw_src)
      PW_INPUT: begin
        pw_addr = PAW'(slot_r);
        pw_data = id_r;
        pw_en   = cmd.path_wr && path_slot_ok;
      end
      PW_MOVE: pw_data = prd_r;
      PW_FILL: pw_data = vrd_r;
      default: pw_en   = 1'b0;
    endcase
  end

  always_comb begin
    case (cmd.pr_sel)
      PR_SLOT: pr_addr = PAW'(slot_r);
      PR_SCAN: pr_addr = i_r;
      PR_MOVE: pr_addr = src_r;
      default: pr_addr = i_r;
    endcase
  end

  always_ff @(posedge clk) begin
    if (pw_en) begin
      path_mem[pw_addr] <= pw_data;
    end
    if (cmd.path_rd) begin
      prd_r <= path_mem[pr_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.vis_wr && vis_slot_ok) begin
      vis_mem[VAW'(slot_r)] <= id_r;
    end
    if (cmd.vis_rd) begin
      vrd_r <= vis_mem[j_r];
    end
  end

  // Scan, plan and copy registers.
  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      op_r    <= op_t'(in_op);
      slot_r  <= in_slot;
      id_r    <= in_poly_id;
      n_r     <= n_sat;
      nv_r    <= nv_sat;
      len_r   <= n_sat;
      found_r <= 1'b0;
      i_r     <= PAW'(n_sat - PLW'(1));
      j_r     <= '0;
    end
    if (cmd.next_v) begin
      j_r <= j_r + VAW'(1);
    end
    if (cmd.next_p) begin
      i_r <= i_r - PAW'(1);
      j_r <= '0;
    end
    if (cmd.hit) begin
      pos_r   <= i_r;
      vpos_r  <= j_r;
      found_r <= 1'b1;
    end
    if (cmd.plan) begin
      req_r  <= PLW'(req_c);
      size_r <= PLW'(size_c);
      pos1_r <= PLW'(pos1_c);
    end
    if (cmd.clip) begin
      up_r <= req_r > pos1_r;
      if (sum_c > CW'(PATH_DEPTH)) begin
        size_r <= PLW'(CW'(PATH_DEPTH) - CW'(req_r));
        len_r  <= PLW'(PATH_DEPTH);
      end else begin
        len_r <= PLW'(sum_c);
      end
    end
    if (cmd.move_init) begin
      cnt_r <= size_r;
      if (up_r) begin
        // Overlap moving up: copy from the far end back.
        src_r <= PAW'(CW'(pos1_r) + CW'(size_r) - CW'(1));
        dst_r <= PAW'(CW'(req_r) + CW'(size_r) - CW'(1));
      end else begin
        src_r <= PAW'(pos1_r);
        dst_r <= PAW'(req_r);
      end
    end
    if (cmd.move_step) begin
      cnt_r <= cnt_r - PLW'(1);
      src_r <= up_r ? src_r - PAW'(1) : src_r + PAW'(1);
      dst_r <= up_r ? dst_r - PAW'(1) : dst_r + PAW'(1);
    end
    if (cmd.fill_init) begin
      cnt_r <= req_r;
      dst_r <= '0;
      j_r   <= VAW'(nv_r - VLW'(1));
    end
    if (cmd.fill_step) begin
      cnt_r <= cnt_r - PLW'(1);
      dst_r <= dst_r + PAW'(1);
      j_r   <= j_r - VAW'(1);
    end
  end

  // Result register.
  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      if (op_r == OP_MERGE) begin
        out_len_r <= (32'(len_r) > 32'(OUT_LEN_MAX)) ? OUT_LEN_MAX : PLEN_W'(len_r);
        out_mrg_r <= found_r;
      end else begin
        out_len_r <= '0;
        out_mrg_r <= 1'b0;
      end
      if (op_r == OP_RD_PATH && path_slot_ok) begin
        out_id_r <= prd_r;
      end else begin
        out_id_r <= '0;
      end
    end
  end

  assign out_new_path_len = out_len_r;
  assign out_read_id      = out_id_r;
  assign out_merged       = out_mrg_r;

  assign sts.op        = op_r;
  assign sts.eq        = (prd_r == vrd_r);
  assign sts.j_last    = (VLW'(j_r) + VLW'(1)) == nv_r;
  assign sts.i_zero    = (i_r == '0);
  assign sts.n_zero    = (n_r == '0);
  assign sts.nv_zero   = (nv_r == '0);
  assign sts.skip_move = (size_r == '0) || (req_r == pos1_r);
  assign sts.cnt_last  = (cnt_r == PLW'(1));

endmodule

`default_nettype wire

FILE: tb/path_corridor_merge_tb.sv
`timescale 1ns / 1ps
// Self-checking testbench for path_corridor_merge: scoreboard class plus stimulus tasks.
// Depends on pcm_pkg for the op codes and field widths; drives the block through its ports.

import pcm_pkg::*;

typedef struct packed {
  logic [PLEN_W-1:0] new_len;
  logic [ID_W-1:0]   rid;
  logic              merged;
} corridor_result_t;

class corridor_scoreboard;
  logic [ID_W-1:0]  path_img [PATH_DEPTH_DEF];
  logic [ID_W-1:0]  vis_img [VISITED_DEPTH_DEF];
  corridor_result_t pending_results [$];
  int unsigned      noted, checked, mismatches, merges, hits, clipped;

  // Find the latest path position holding a visited id, then splice the reversed
  // visited prefix in front of the remaining tail.
  function corridor_result_t merge_corridor(logic [PLEN_W-1:0] plen, logic [VLEN_W-1:0] vlen);
    corridor_result_t res;
    logic [ID_W-1:0]  snap [PATH_DEPTH_DEF];
    int unsigned      n, nv, pos, vpos, req, size;
    bit               found;
    res   = '0;
    n     = (plen > PATH_DEPTH_DEF) ? PATH_DEPTH_DEF : plen;
    nv    = (vlen > VISITED_DEPTH_DEF) ? VISITED_DEPTH_DEF : vlen;
    found = 1'b0;
    pos   = 0;
    vpos  = 0;
    merges++;
    for (int k = n; k > 0 && !found; k--)
      for (int j = 0; j < nv && !found; j++)
        if (path_img[k-1] == vis_img[j]) begin
          pos   = k - 1;
          vpos  = j;
          found = 1'b1;
        end
    if (!found) begin
      res.new_len = PLEN_W'(n);
      return res;
    end
    hits++;
    req  = nv - vpos;
    size = n - pos - 1;
    if (req >= PATH_DEPTH_DEF) begin
      req  = PATH_DEPTH_DEF;
      size = 0;
    end else if (req + size > PATH_DEPTH_DEF) begin
      size = PATH_DEPTH_DEF - req;
      clipped++;
    end
    snap = path_img;
    for (int t = 0; t < size; t++) path_img[req+t] = snap[pos+1+t];
    for (int t = 0; t < req; t++) path_img[t] = vis_img[nv-1-t];
    res.new_len = (req + size > OUT_LEN_MAX) ? OUT_LEN_MAX : PLEN_W'(req + size);
    res.merged  = 1'b1;
    return res;
  endfunction

  function void note_transaction(op_t op, logic [SLOT_W-1:0] slot, logic [ID_W-1:0] id,
                                 logic [PLEN_W-1:0] plen, logic [VLEN_W-1:0] vlen);
    corridor_result_t res;
    res = '0;
    noted++;
    case (op)
      OP_WR_PATH: path_img[slot] = id;
      OP_WR_VIS:  if (slot < VISITED_DEPTH_DEF) vis_img[slot] = id;
      OP_MERGE:   res = merge_corridor(plen, vlen);
      OP_RD_PATH: res.rid = path_img[slot];
      default: ;
    endcase
    pending_results.push_back(res);
  endfunction

  function void check_result(logic [PLEN_W-1:0] nlen, logic [ID_W-1:0] rid, logic mrg);
    corridor_result_t want;
    if (pending_results.size() == 0) begin
      mismatches++;
      if (mismatches <= 10)
        $display("unexpected result: len %0d id %h merged %b", nlen, rid, mrg);
      return;
    end
    want = pending_results.pop_front();
    checked++;
    if (want.new_len !== nlen || want.rid !== rid || want.merged !== mrg) begin
      mismatches++;
      if (mismatches <= 10)
        $display("result %0d: expected len %0d id %h merged %b, got len %0d id %h merged %b",
                 checked, want.new_len, want.rid, want.merged, nlen, rid, mrg);
    end
  endfunction
endclass

module path_corridor_merge_tb;

  // Longest quiet stretch: a full-depth merge with no match, plus the long receiver
  // hold and sender gaps. Take it several times over.
  localparam int WATCHDOG_LIMIT = 60000;
  localparam int RANDOM_ITEMS   = 570;
  localparam int HOLD_CYCLES    = 500;

  typedef enum int {RX_FLOW, RX_LIGHT, RX_HEAVY, RX_TOGGLE} rx_mode_t;

  logic              clk            = 1'b0;
  logic              rst_n          = 1'b0;
  logic              in_valid       = 1'b0;
  logic              in_stall;
  logic [OP_W-1:0]   in_op          = '0;
  logic [SLOT_W-1:0] in_slot        = '0;
  logic [ID_W-1:0]   in_poly_id     = '0;
  logic [PLEN_W-1:0] in_path_len    = '0;
  logic [VLEN_W-1:0] in_visited_len = '0;
  logic              out_valid;
  logic              out_stall      = 1'b0;
  logic [PLEN_W-1:0] out_new_path_len;
  logic [ID_W-1:0]   out_read_id;
  logic              out_merged;

  corridor_scoreboard sb = new();
  int unsigned        burst_left;
  int unsigned        idle_cycles;

  path_corridor_merge u_top (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_stall         (in_stall),
    .in_op            (in_op),
    .in_slot          (in_slot),
    .in_poly_id       (in_poly_id),
    .in_path_len      (in_path_len),
    .in_visited_len   (in_visited_len),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .out_new_path_len (out_new_path_len),
    .out_read_id      (out_read_id),
    .out_merged       (out_merged)
  );

  initial begin
    forever #6 clk = ~clk;
  end

  // Offer one transaction and hold it until the block takes it. Called right after
  // a rising edge. Bursts of back-to-back transactions are broken by random gaps;
  // valid is lowered only when a gap follows, so it never toggles within one step.
  task automatic issue(op_t op, logic [SLOT_W-1:0] slot, logic [ID_W-1:0] id,
                       logic [PLEN_W-1:0] plen, logic [VLEN_W-1:0] vlen);
    in_valid       <= 1'b1;
    in_op          <= op;
    in_slot        <= slot;
    in_poly_id     <= id;
    in_path_len    <= plen;
    in_visited_len <= vlen;
    do @(posedge clk); while (in_stall);
    sb.note_transaction(op, slot, id, plen, vlen);
    if (burst_left > 0) begin
      burst_left--;
    end else begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 8)) @(posedge clk);
      burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(40, 80) : $urandom_range(0, 12);
    end
  endtask

  // Draw ids mostly from a tiny pool so that merges find common ids often.
  function automatic logic [ID_W-1:0] pool_id();
    if ($urandom_range(0, 3) == 0) return $urandom;
    return ID_W'($urandom_range(0, 11));
  endfunction

  // Keep most merges short; a few walk the whole path store.
  function automatic logic [PLEN_W-1:0] pick_path_len();
    if ($urandom_range(0, 11) == 0) return PLEN_W'($urandom_range(25, 511));
    return PLEN_W'($urandom_range(0, 24));
  endfunction

  function automatic logic [VLEN_W-1:0] pick_visited_len();
    if ($urandom_range(0, 7) == 0) return VLEN_W'($urandom_range(17, 31));
    return VLEN_W'($urandom_range(0, 16));
  endfunction

  // Stimulus: directed checks on a few low entries, then a full fill of both stores
  // with a planted match near the head, then random corridor sequences and noise.
  initial begin
    int unsigned       random_start;
    int unsigned       anchor_vpos;
    logic [ID_W-1:0]   anchor_id;
    logic [ID_W-1:0]   fill_id;
    op_t               noise_op;
    burst_left = 4;
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Extremes of the id field, and visited writes outside the store (dropped).
    issue(OP_WR_PATH, 8'd0, 32'h0000_0000, '0, '0);
    issue(OP_WR_PATH, 8'd1, 32'hFFFF_FFFF, '0, '0);
    issue(OP_WR_PATH, 8'd2, 32'hA5A5_A5A5, '0, '0);
    issue(OP_WR_PATH, 8'd3, 32'h0000_0007, '0, '0);
    issue(OP_WR_VIS, 8'd0, 32'h0000_0007, '0, '0);
    issue(OP_WR_VIS, 8'd1, 32'hFFFF_FFFF, '0, '0);
    issue(OP_WR_VIS, 8'd16, 32'h1234_5678, '0, '0);
    issue(OP_WR_VIS, 8'd255, 32'h0000_0007, '0, '0);
    issue(OP_RD_PATH, 8'd0, '0, '0, '0);
    issue(OP_RD_PATH, 8'd1, '0, '0, '0);
    // Empty path, then empty visited list: no match, length passes through.
    issue(OP_MERGE, '0, '0, 9'd0, 5'd2);
    issue(OP_MERGE, '0, '0, 9'd4, 5'd0);
    // Match on the last entry: no tail survives.
    issue(OP_MERGE, '0, '0, 9'd4, 5'd2);
    issue(OP_RD_PATH, 8'd0, '0, '0, '0);
    issue(OP_RD_PATH, 8'd1, '0, '0, '0);
    // Match in the middle: the tail moves down behind the prefix.
    issue(OP_WR_VIS, 8'd0, 32'hA5A5_A5A5, '0, '0);
    issue(OP_WR_VIS, 8'd1, 32'h1234_5678, '0, '0);
    issue(OP_MERGE, 8'hFF, 32'hDEAD_BEEF, 9'd4, 5'd2);
    issue(OP_RD_PATH, 8'd2, '0, '0, '0);
    // No common id over a non-empty path.
    issue(OP_WR_VIS, 8'd0, 32'h0000_0000, '0, '0);
    issue(OP_MERGE, 8'h5A, 32'hFFFF_FFFF, 9'd3, 5'd1);

    random_start = sb.noted;

    // Fill every entry: path ids have the top bit clear, visited ids set, so only the
    // planted visited entry matches, at path position one. A long prefix in front of
    // a long tail overflows the path store and gets clipped.
    for (int k = 0; k < PATH_DEPTH_DEF; k++) begin
      fill_id = ($urandom & 32'h7FFF_FF00) | ID_W'(k);
      if (k == 1) anchor_id = fill_id;
      issue(OP_WR_PATH, SLOT_W'(k), fill_id, PLEN_W'($urandom), VLEN_W'($urandom));
    end
    for (int j = 0; j < VISITED_DEPTH_DEF; j++) begin
      fill_id = ($urandom & 32'h7FFF_FF00) | 32'h8000_0000 | ID_W'(j);
      issue(OP_WR_VIS, SLOT_W'(j), fill_id, PLEN_W'($urandom), VLEN_W'($urandom));
    end
    anchor_vpos = $urandom_range(0, 5);
    issue(OP_WR_VIS, SLOT_W'(anchor_vpos), anchor_id, '0, '0);
    issue(OP_MERGE, SLOT_W'($urandom), $urandom, PLEN_W'($urandom_range(256, 511)),
          VLEN_W'($urandom_range(16, 31)));

    // Every entry is written now, so any read or merge is legal.
    while (sb.noted - random_start < RANDOM_ITEMS) begin
      if ($urandom_range(0, 99) < 75) begin
        // Corridor update: a few path and visited writes, a merge, then read back.
        repeat ($urandom_range(1, 6))
          issue(OP_WR_PATH, SLOT_W'($urandom_range(0, 23)), pool_id(),
                PLEN_W'($urandom), VLEN_W'($urandom));
        repeat ($urandom_range(0, 4))
          issue(OP_WR_VIS, SLOT_W'($urandom_range(0, 15)), pool_id(),
                PLEN_W'($urandom), VLEN_W'($urandom));
        issue(OP_MERGE, SLOT_W'($urandom), $urandom, pick_path_len(), pick_visited_len());
        repeat ($urandom_range(0, 3))
          issue(OP_RD_PATH, SLOT_W'($urandom_range(0, 24)), $urandom,
                PLEN_W'($urandom), VLEN_W'($urandom));
      end else begin
        // Noise: any operation with unconstrained fields.
        noise_op = op_t'($urandom_range(0, 3));
        issue(noise_op, SLOT_W'($urandom), $urandom,
              (noise_op == OP_MERGE) ? pick_path_len() : PLEN_W'($urandom),
              (noise_op == OP_MERGE) ? pick_visited_len() : VLEN_W'($urandom));
      end
    end
    in_valid <= 1'b0;

    while (sb.pending_results.size() != 0) @(posedge clk);
    repeat (30) @(posedge clk);

    $display("covered %0d transactions, %0d results checked, %0d merges",
             sb.noted, sb.checked, sb.merges);
    $display("merges with a common id: %0d, clipped at the path depth: %0d, mismatches: %0d",
             sb.hits, sb.clipped, sb.mismatches);
    if (sb.mismatches == 0 && sb.pending_results.size() == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

  // Result side: check each accepted result, then pick the next stall value. Once,
  // hold off for a long stretch so the block fills and stalls its input.
  initial begin
    int unsigned hold_left;
    int unsigned seg_left;
    bit          held;
    rx_mode_t    mode;
    hold_left = 0;
    seg_left  = 0;
    held      = 1'b0;
    mode      = RX_FLOW;
    forever begin
      @(posedge clk);
      if (rst_n && out_valid && !out_stall)
        sb.check_result(out_new_path_len, out_read_id, out_merged);
      if (!held && sb.noted >= 150) begin
        held      = 1'b1;
        hold_left = HOLD_CYCLES;
      end
      if (seg_left == 0) begin
        mode     = rx_mode_t'($urandom_range(0, 3));
        seg_left = $urandom_range(10, 200);
      end else begin
        seg_left--;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_stall <= 1'b1;
      end else begin
        case (mode)
          RX_FLOW:  out_stall <= 1'b0;
          RX_LIGHT: out_stall <= ($urandom_range(0, 3) == 0);
          RX_HEAVY: out_stall <= ($urandom_range(0, 9) < 6);
          default:  out_stall <= ~out_stall;
        endcase
      end
    end
  end

  // Watchdog: count cycles with no transaction on either channel.
  always @(posedge clk) begin
    if (rst_n) begin
      if ((in_valid && !in_stall) || (out_valid && !out_stall)) begin
        idle_cycles <= 0;
      end else if (idle_cycles >= WATCHDOG_LIMIT) begin
        $display("watchdog: no transaction for %0d cycles", idle_cycles);
        $display("end of test: mismatches");
        $finish;
      end else begin
        idle_cycles <= idle_cycles + 1;
      end
    end else begin
      idle_cycles <= 0;
    end
  end

endmodule
